@@ hdl/calu_pkg.sv @@
`default_nettype none

package calu_pkg;

  typedef enum logic [4:0] {
    K_OR      = 5'd0,
    K_AND     = 5'd1,
    K_XOR     = 5'd2,
    K_ADC     = 5'd3,
    K_SBC     = 5'd4,
    K_CMP     = 5'd5,
    K_BIT     = 5'd6,
    K_BIT_IMM = 5'd7,
    K_ASL     = 5'd8,
    K_LSR     = 5'd9,
    K_ROL     = 5'd10,
    K_ROR     = 5'd11,
    K_INC     = 5'd12,
    K_DEC     = 5'd13,
    K_LOAD    = 5'd14,
    K_TSB     = 5'd15,
    K_TRB     = 5'd16
  } kind_e;

  // status bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  localparam logic [15:0] MaskWide   = 16'hFFFF;
  localparam logic [15:0] MaskNarrow = 16'h00FF;
  localparam logic [15:0] SignWide   = 16'h8000;
  localparam logic [15:0] SignNarrow = 16'h0080;

  // operands after width masking
  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  reg_hi;
    logic [15:0] a;
    logic [15:0] v;
    logic [15:0] b;       // addend: v, or its complement for subtract and compare
    logic        cin;
    logic        narrow;
    logic [7:0]  status;
  } s1_t;

  // binary sum, logic and shift results, low BCD byte
  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  reg_hi;
    logic [15:0] a;
    logic [15:0] v;
    logic [15:0] b;
    logic        narrow;
    logic [7:0]  status;
    logic [16:0] bin;
    logic [15:0] lres;
    logic        lc;
    logic        and_zero;
    logic [7:0]  bcd_lo;
    logic        bcd_c1;
  } s2_t;

  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  status;
    logic        writes;
  } res_t;

  // one packed BCD digit step; cy is carry for add and not-borrow for subtract
  // returns {carry out, digit}
  function automatic logic [4:0] bcd_digit(input logic [3:0] x, input logic [3:0] y,
                                           input logic cy, input logic sub);
    logic [5:0] s;
    begin
      if (!sub) begin
        s = {2'b00, x} + {2'b00, y} + {5'b00000, cy};
        if (s > 6'd9) s = s + 6'd6;
        bcd_digit = {(s > 6'd15), s[3:0]};
      end else begin
        s = {2'b00, x} - {2'b00, y} - {5'b00000, ~cy};
        if (s[5]) s = s - 6'd6;
        bcd_digit = {~s[5], s[3:0]};
      end
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/cpu_alu_8_16_bcd_top.sv @@
`default_nettype none

// channel   handshake                  payload
// -------   -------------------------  ------------------------------------------------
// in        in_valid_i / in_stall_o    kind_i reg_value_i operand_i narrow_i status_in_i
// out       out_valid_o / out_stall_i  result_o status_out_o writes_value_o
//
// Three register stages: operand masking, binary add plus logic, shifts and the
// low BCD byte, then the high BCD byte with result select and flag update.
// One transfer per cycle sustained while the output is not stalled; each item passes
// one register per stage, with the four-digit BCD carry chain split over the last two.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall on the output holds each stage that is full and whose successor
// cannot take its item; empty stages still fill, so no transfer is lost.

module cpu_alu_8_16_bcd_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [4:0]  kind_i,
  input  wire logic [15:0] reg_value_i,
  input  wire logic [15:0] operand_i,
  input  wire logic        narrow_i,
  input  wire logic [7:0]  status_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      result_o,
  output logic [7:0]       status_out_o,
  output logic             writes_value_o
);
  import calu_pkg::*;

  logic  v1, v2, v3;
  logic  en1, en2, en3;
  s1_t   s1;
  s2_t   s2;
  res_t  res;

  // a stage advances when it is empty or the one after it advances
  assign en3        = !v3 || !out_stall_i;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign in_stall_o = !en1;

  calu_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en1),
    .valid_i     (in_valid_i),
    .kind_i      (kind_i),
    .reg_value_i (reg_value_i),
    .operand_i   (operand_i),
    .narrow_i    (narrow_i),
    .status_in_i (status_in_i),
    .valid_o     (v1),
    .item_o      (s1)
  );

  calu_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .item_i  (s1),
    .valid_o (v2),
    .item_o  (s2)
  );

  calu_final u_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .item_i  (s2),
    .valid_o (v3),
    .res_o   (res)
  );

  assign out_valid_o    = v3;
  assign result_o       = res.result;
  assign status_out_o   = res.status;
  assign writes_value_o = res.writes;

endmodule

`default_nettype wire

@@ hdl/calu_prep.sv @@
`default_nettype none

module calu_prep (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         valid_i,
  input  wire logic [4:0]   kind_i,
  input  wire logic [15:0]  reg_value_i,
  input  wire logic [15:0]  operand_i,
  input  wire logic         narrow_i,
  input  wire logic [7:0]   status_in_i,
  output logic              valid_o,
  output calu_pkg::s1_t     item_o
);
  import calu_pkg::*;

  logic [15:0] mask;
  logic        is_sub;
  s1_t         item_d, item_q;
  logic        valid_q;

  always_comb begin
    mask          = narrow_i ? MaskNarrow : MaskWide;
    is_sub        = (kind_i == K_SBC) || (kind_i == K_CMP);
    item_d.kind   = kind_i;
    item_d.reg_hi = reg_value_i[15:8];
    item_d.a      = reg_value_i & mask;
    item_d.v      = operand_i & mask;
    item_d.b      = is_sub ? (~operand_i & mask) : (operand_i & mask);
    // compare is a subtract with no borrow in
    item_d.cin    = (kind_i == K_CMP) ? 1'b1 : status_in_i[FlagC];
    item_d.narrow = narrow_i;
    item_d.status = status_in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ hdl/calu_exec.sv @@
`default_nettype none

module calu_exec (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire calu_pkg::s1_t item_i,
  output logic               valid_o,
  output calu_pkg::s2_t      item_o
);
  import calu_pkg::*;

  logic [15:0] mask;
  logic [15:0] sign;
  logic        cy;
  logic        sub;
  logic [4:0]  dig0;
  logic [4:0]  dig1;
  s2_t         item_d, item_q;
  logic        valid_q;

  always_comb begin
    mask = item_i.narrow ? MaskNarrow : MaskWide;
    sign = item_i.narrow ? SignNarrow : SignWide;
    cy   = item_i.status[FlagC];
    sub  = (item_i.kind == K_SBC);

    item_d.kind     = item_i.kind;
    item_d.reg_hi   = item_i.reg_hi;
    item_d.a        = item_i.a;
    item_d.v        = item_i.v;
    item_d.b        = item_i.b;
    item_d.narrow   = item_i.narrow;
    item_d.status   = item_i.status;
    item_d.bin      = {1'b0, item_i.a} + {1'b0, item_i.b} + {16'h0000, item_i.cin};
    item_d.and_zero = ((item_i.a & item_i.v) == 16'h0000);

    // low two decimal digits
    dig0 = bcd_digit(item_i.a[3:0], item_i.v[3:0], cy, sub);
    dig1 = bcd_digit(item_i.a[7:4], item_i.v[7:4], dig0[4], sub);
    item_d.bcd_lo = {dig1[3:0], dig0[3:0]};
    item_d.bcd_c1 = dig1[4];

    item_d.lc = 1'b0;
    case (item_i.kind)
      K_OR:    item_d.lres = item_i.a | item_i.v;
      K_AND:   item_d.lres = item_i.a & item_i.v;
      K_XOR:   item_d.lres = item_i.a ^ item_i.v;
      K_ASL: begin
        item_d.lres = (item_i.a << 1) & mask;
        item_d.lc   = |(item_i.a & sign);
      end
      K_LSR: begin
        item_d.lres = item_i.a >> 1;
        item_d.lc   = item_i.a[0];
      end
      K_ROL: begin
        item_d.lres = ((item_i.a << 1) | {15'h0000, cy}) & mask;
        item_d.lc   = |(item_i.a & sign);
      end
      K_ROR: begin
        item_d.lres = (item_i.a >> 1) | (cy ? sign : 16'h0000);
        item_d.lc   = item_i.a[0];
      end
      K_INC:   item_d.lres = (item_i.a + 16'h0001) & mask;
      K_DEC:   item_d.lres = (item_i.a - 16'h0001) & mask;
      K_LOAD:  item_d.lres = item_i.v;
      K_TSB:   item_d.lres = item_i.v | item_i.a;
      K_TRB:   item_d.lres = item_i.v & ~item_i.a;
      default: item_d.lres = item_i.a;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ hdl/calu_final.sv @@
`default_nettype none

module calu_final (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire calu_pkg::s2_t item_i,
  output logic               valid_o,
  output calu_pkg::res_t     res_o
);
  import calu_pkg::*;

  logic [15:0] mask;
  logic [15:0] sign;
  logic        sub;
  logic [4:0]  dig2;
  logic [4:0]  dig3;
  logic [15:0] bcd_r;
  logic        bcd_c;
  logic        bin_c;
  logic        ovf;
  logic [15:0] r;
  logic [15:0] rm;
  logic [15:0] cmp_r;
  logic [7:0]  p;
  logic        wr;
  logic        set_nz;
  logic [15:0] nz_val;
  res_t        res_d, res_q;
  logic        valid_q;

  always_comb begin
    mask = item_i.narrow ? MaskNarrow : MaskWide;
    sign = item_i.narrow ? SignNarrow : SignWide;
    sub  = (item_i.kind == K_SBC);

    // high two decimal digits; narrow takes its carry after the second digit
    dig2  = bcd_digit(item_i.a[11:8], item_i.v[11:8], item_i.bcd_c1, sub);
    dig3  = bcd_digit(item_i.a[15:12], item_i.v[15:12], dig2[4], sub);
    bcd_r = {dig3[3:0], dig2[3:0], item_i.bcd_lo};
    bcd_c = item_i.narrow ? item_i.bcd_c1 : dig3[4];

    bin_c = item_i.narrow ? item_i.bin[8] : item_i.bin[16];
    // overflow from the binary sum, decimal mode too
    ovf   = |(~(item_i.a ^ item_i.b) & (item_i.a ^ item_i.bin[15:0]) & sign);
    cmp_r = item_i.bin[15:0] & mask;

    p      = item_i.status;
    r      = item_i.a;
    wr     = 1'b1;
    set_nz = 1'b0;
    nz_val = 16'h0000;

    case (item_i.kind)
      K_OR, K_AND, K_XOR, K_INC, K_DEC, K_LOAD: begin
        r      = item_i.lres;
        set_nz = 1'b1;
      end
      K_ASL, K_LSR, K_ROL, K_ROR: begin
        r        = item_i.lres;
        p[FlagC] = item_i.lc;
        set_nz   = 1'b1;
      end
      K_ADC, K_SBC: begin
        r        = item_i.status[FlagD] ? bcd_r : (item_i.bin[15:0] & mask);
        p[FlagC] = item_i.status[FlagD] ? bcd_c : bin_c;
        p[FlagV] = ovf;
        set_nz   = 1'b1;
      end
      K_CMP: begin
        p[FlagC] = bin_c;
        p[FlagN] = |(cmp_r & sign);
        p[FlagZ] = (cmp_r == 16'h0000);
        wr       = 1'b0;
      end
      K_BIT: begin
        p[FlagN] = item_i.narrow ? item_i.v[7] : item_i.v[15];
        p[FlagV] = item_i.narrow ? item_i.v[6] : item_i.v[14];
        p[FlagZ] = item_i.and_zero;
        wr       = 1'b0;
      end
      K_BIT_IMM: begin
        p[FlagZ] = item_i.and_zero;
        wr       = 1'b0;
      end
      K_TSB, K_TRB: begin
        r        = item_i.lres;
        p[FlagZ] = item_i.and_zero;
      end
      default: begin
        wr = 1'b0;
      end
    endcase

    rm = r & mask;
    if (set_nz) begin
      nz_val   = rm;
      p[FlagN] = |(nz_val & sign);
      p[FlagZ] = (nz_val == 16'h0000);
    end

    res_d.result = item_i.narrow ? {item_i.reg_hi, rm[7:0]} : rm;
    res_d.status = p;
    res_d.writes = wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire
